// ===== src/uuidp_pkg.sv =====
// ----------------------------------------------------------------------------
// uuidp_pkg
// Shared types, constants and helper functions for the UUID text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package uuidp_pkg;

   // Width of the saturating character position.
   localparam int unsigned PosW = 6;
   localparam logic [PosW-1:0] POS_MAX = 6'd63;

   // Form codes.
   localparam logic [1:0] FORM_PLAIN = 2'd0;
   localparam logic [1:0] FORM_HYPH  = 2'd1;
   localparam logic [1:0] FORM_BRACE = 2'd2;
   localparam logic [1:0] FORM_URN   = 2'd3;

   // Total string length of each form, one bit wider than the position.
   localparam logic [PosW:0] LEN_PLAIN = 7'd32;
   localparam logic [PosW:0] LEN_HYPH  = 7'd36;
   localparam logic [PosW:0] LEN_BRACE = 7'd38;
   localparam logic [PosW:0] LEN_URN   = 7'd45;

   // Byte count of each of the first four of the 8-4-4-4-12 groups.
   localparam int unsigned GROUP_BYTES0 = 4;
   localparam int unsigned GROUP_BYTES1 = 2;
   localparam int unsigned GROUP_BYTES2 = 2;
   localparam int unsigned GROUP_BYTES3 = 2;

   // Hyphen positions within the 36-character body.
   localparam int unsigned HYPH_AT0 = GROUP_BYTES0 * 2;
   localparam int unsigned HYPH_AT1 = HYPH_AT0 + 1 + GROUP_BYTES1 * 2;
   localparam int unsigned HYPH_AT2 = HYPH_AT1 + 1 + GROUP_BYTES2 * 2;
   localparam int unsigned HYPH_AT3 = HYPH_AT2 + 1 + GROUP_BYTES3 * 2;

   // Length of the "urn:uuid:" prefix.
   localparam logic [PosW-1:0] URN_PREFIX_LEN = 6'd9;

   // Special characters.
   localparam logic [7:0] CHAR_DASH   = 8'h2D;
   localparam logic [7:0] CHAR_LBRACE = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE = 8'h7D;
   localparam logic [7:0] CHAR_LOW_U  = 8'h75;
   localparam logic [7:0] CASE_BIT    = 8'h20;

   // Classification of one character, handed from the classifier to the top.
   typedef struct packed {
      logic       hex_ok;
      logic [3:0] hex_val;
      logic       is_dash;
      logic       is_lbrace;
      logic       is_rbrace;
      logic [7:0] lower;
   } char_class_type;

   // Character expected at each place of the lower-case "urn:uuid:" prefix.
   function automatic logic [7:0] urn_prefix_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = 8'h75;  // u
         4'd1:    ch = 8'h72;  // r
         4'd2:    ch = 8'h6E;  // n
         4'd3:    ch = 8'h3A;  // :
         4'd4:    ch = 8'h75;  // u
         4'd5:    ch = 8'h75;  // u
         4'd6:    ch = 8'h69;  // i
         4'd7:    ch = 8'h64;  // d
         4'd8:    ch = 8'h3A;  // :
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // True where the 36-character body holds a hyphen.
   function automatic logic is_hyphen_slot(input logic [PosW-1:0] body);
      return (body == PosW'(HYPH_AT0)) || (body == PosW'(HYPH_AT1)) ||
             (body == PosW'(HYPH_AT2)) || (body == PosW'(HYPH_AT3));
   endfunction

endpackage

`default_nettype wire

// ===== src/uuidp_char_class.sv =====
// ----------------------------------------------------------------------------
// uuidp_char_class
// Classifies one character: hex digit value, separators and lower-case form.
// ----------------------------------------------------------------------------
`default_nettype none

module uuidp_char_class
   import uuidp_pkg::*;
(
   input  wire logic [7:0]     char_in,
   output char_class_type      cls
);

   // Hex digit decode in either case, the separators and the folded letter.
   always_comb begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = 4'd0;
      if (char_in >= 8'h30 && char_in <= 8'h39) begin
         cls.hex_val = 4'(char_in - 8'h30);
      end else if (char_in >= 8'h61 && char_in <= 8'h66) begin
         cls.hex_val = 4'(char_in - 8'h57);
      end else if (char_in >= 8'h41 && char_in <= 8'h46) begin
         cls.hex_val = 4'(char_in - 8'h37);
      end else begin
         cls.hex_ok  = 1'b0;
      end

      // Separators.
      cls.is_dash   = (char_in == CHAR_DASH);
      cls.is_lbrace = (char_in == CHAR_LBRACE);
      cls.is_rbrace = (char_in == CHAR_RBRACE);

      // Only upper-case letters are folded.
      cls.lower = (char_in >= 8'h41 && char_in <= 8'h5A) ? (char_in | CASE_BIT) : char_in;
   end

endmodule

`default_nettype wire

// ===== src/uuid_text_parser.sv =====
// ----------------------------------------------------------------------------
// uuid_text_parser
// Streams a UUID text one character per item and reports validity and the
// 128-bit value on the character marked last.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  req_      in         req_valid/req_stall  req_char_in, req_is_last
//  rsp_      out        rsp_valid/rsp_stall  rsp_valid_res, rsp_uuid_high, rsp_uuid_low
//
// One character is taken every cycle unless the input is stalled; a result
// follows its last character through the input register, then the result register.
// Reset is synchronous and clears both stages and the parse state.
// Only an item marked last waits on a stalled result register; other
// characters keep flowing while a result is held.
// ----------------------------------------------------------------------------
`default_nettype none

module uuid_text_parser
   import uuidp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_char_in,
   input  wire logic        req_is_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_valid_res,
   output logic [63:0]      rsp_uuid_high,
   output logic [63:0]      rsp_uuid_low
);

   // Input register.
   logic                in_vld_ff, in_vld_in;
   logic [7:0]          in_char_ff;
   logic                in_last_ff;

   // Parse state.
   logic [PosW-1:0]     pos_ff, pos_in;
   logic [1:0]          form_ff, form_in;
   logic                err_ff, err_in;
   logic [63:0]         acc_hi_ff, acc_hi_in;
   logic [63:0]         acc_lo_ff, acc_lo_in;

   // Result register.
   logic                out_vld_ff, out_vld_in;
   logic                out_ok_ff;
   logic [63:0]         out_hi_ff;
   logic [63:0]         out_lo_ff;

   logic                advance;
   logic                take_req;
   char_class_type      cls;
   logic [1:0]          form_cur;
   logic                hex_take;
   logic                body_take;
   logic [PosW-1:0]     body_idx;
   logic                err_now;
   logic [PosW:0]       len_need;
   logic                ok;
   logic [63:0]         acc_hi_nx;
   logic [63:0]         acc_lo_nx;

   uuidp_char_class u_class (
      .char_in (in_char_ff),
      .cls     (cls)
   );

   // A held character moves on unless it is last and the result is stuck.
   assign advance   = in_vld_ff && (!in_last_ff || !out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign take_req  = req_valid && !req_stall;
   assign in_vld_in = take_req || (in_vld_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_char_ff <= req_char_in;
         in_last_ff <= req_is_last;
      end
   end

   // Form selection: first character picks urn, braced or plain, ninth may pick hyphenated.
   always_comb begin
      if (pos_ff == '0) begin
         if ((in_char_ff | CASE_BIT) == CHAR_LOW_U) begin
            form_cur = FORM_URN;
         end else if (cls.is_lbrace) begin
            form_cur = FORM_BRACE;
         end else begin
            form_cur = FORM_PLAIN;
         end
      end else begin
         form_cur = form_ff;
      end
      if (form_cur == FORM_PLAIN && pos_ff == PosW'(HYPH_AT0) && cls.is_dash) begin
         form_cur = FORM_HYPH;
      end
   end

   // Check the character against its place and decide whether it is a digit.
   always_comb begin
      err_now   = 1'b0;
      hex_take  = 1'b0;
      body_take = 1'b0;
      body_idx  = pos_ff;
      case (form_cur)
         FORM_PLAIN: begin
            if (pos_ff < PosW'(LEN_PLAIN)) begin
               hex_take = 1'b1;
            end else begin
               err_now = 1'b1;
            end
         end
         FORM_HYPH: begin
            if (pos_ff < PosW'(LEN_HYPH)) begin
               body_take = 1'b1;
            end else begin
               err_now = 1'b1;
            end
         end
         FORM_BRACE: begin
            body_idx = pos_ff - 1'b1;
            if (pos_ff == '0) begin
               err_now = !cls.is_lbrace;
            end else if (pos_ff <= PosW'(LEN_HYPH)) begin
               body_take = 1'b1;
            end else if (pos_ff == PosW'(LEN_BRACE - 1'b1)) begin
               err_now = !cls.is_rbrace;
            end else begin
               err_now = 1'b1;
            end
         end
         default: begin
            body_idx = pos_ff - URN_PREFIX_LEN;
            if (pos_ff < URN_PREFIX_LEN) begin
               err_now = (cls.lower != urn_prefix_char(pos_ff[3:0]));
            end else if (pos_ff < PosW'(LEN_URN)) begin
               body_take = 1'b1;
            end else begin
               err_now = 1'b1;
            end
         end
      endcase
      // Inside the grouped body a slot holds either a hyphen or a digit.
      if (body_take) begin
         if (is_hyphen_slot(body_idx)) begin
            err_now = !cls.is_dash;
         end else begin
            hex_take = 1'b1;
         end
      end
      if (hex_take && !cls.hex_ok) begin
         err_now  = 1'b1;
         hex_take = 1'b0;
      end
   end

   // Value with the current digit shifted in, when the character is one.
   always_comb begin
      acc_hi_nx = acc_hi_ff;
      acc_lo_nx = acc_lo_ff;
      if (hex_take) begin
         acc_hi_nx = {acc_hi_ff[59:0], acc_lo_ff[63:60]};
         acc_lo_nx = {acc_lo_ff[59:0], cls.hex_val};
      end
   end

   // Required length for the chosen form.
   always_comb begin
      case (form_cur)
         FORM_PLAIN: len_need = LEN_PLAIN;
         FORM_HYPH:  len_need = LEN_HYPH;
         FORM_BRACE: len_need = LEN_BRACE;
         default:    len_need = LEN_URN;
      endcase
   end

   assign ok = !(err_ff || err_now) && ({1'b0, pos_ff} + 1'b1 == len_need);

   // Next parse state; a last character returns everything to reset values.
   always_comb begin
      pos_in    = pos_ff;
      form_in   = form_ff;
      err_in    = err_ff;
      acc_hi_in = acc_hi_ff;
      acc_lo_in = acc_lo_ff;
      if (advance) begin
         if (in_last_ff) begin
            pos_in    = '0;
            form_in   = FORM_PLAIN;
            err_in    = 1'b0;
            acc_hi_in = '0;
            acc_lo_in = '0;
         end else begin
            pos_in    = (pos_ff < POS_MAX) ? pos_ff + 1'b1 : POS_MAX;
            form_in   = form_cur;
            err_in    = err_ff || err_now;
            acc_hi_in = acc_hi_nx;
            acc_lo_in = acc_lo_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         form_ff   <= FORM_PLAIN;
         err_ff    <= 1'b0;
         acc_hi_ff <= '0;
         acc_lo_ff <= '0;
      end else begin
         pos_ff    <= pos_in;
         form_ff   <= form_in;
         err_ff    <= err_in;
         acc_hi_ff <= acc_hi_in;
         acc_lo_ff <= acc_lo_in;
      end
   end

   // Result register: loaded by a last character, emptied when taken.
   assign out_vld_in = (advance && in_last_ff) || (out_vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   // The last character's own digit is part of the reported value.
   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         out_ok_ff <= ok;
         out_hi_ff <= ok ? acc_hi_nx : '0;
         out_lo_ff <= ok ? acc_lo_nx : '0;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_valid_res = out_ok_ff;
   assign rsp_uuid_high = out_hi_ff;
   assign rsp_uuid_low  = out_lo_ff;

endmodule

`default_nettype wire

// ===== src/uuidp_checker.sv =====
// ----------------------------------------------------------------------------
// uuidp_checker
// Port-level checks on the UUID text parser, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module uuidp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_valid_res,
   input wire logic [63:0] rsp_uuid_high,
   input wire logic [63:0] rsp_uuid_low
);

   // A stalled result stays presented and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_valid_res) &&
         $stable(rsp_uuid_high) && $stable(rsp_uuid_low))
      else $error("stalled result changed");

   // A rejected string carries a zero value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_uuid_high == 64'd0 && rsp_uuid_low == 64'd0)
      else $error("invalid result with nonzero value");

   // Nothing is presented or stalled in the first cycle after reset.
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && !req_stall)
      else $error("output not empty after reset");

   // The input is held off only while a result is stuck at the output.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back-pressure");

endmodule

bind uuid_text_parser uuidp_checker u_uuidp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_valid_res (rsp_valid_res),
   .rsp_uuid_high (rsp_uuid_high),
   .rsp_uuid_low  (rsp_uuid_low)
);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the UUID text parser. UUID strings in the four
// forms (plain, hyphenated, braced, urn) are streamed one character per item.
// Damaged strings and random noise are mixed in, and idling is random on both
// channels. A local parse model predicts each result, and a monitor compares
// every accepted result with the oldest pending prediction.
// ----------------------------------------------------------------------------

module tb
   import uuidp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 200000;

   // Characters used to build test strings.
   localparam logic [7:0] CH_ZERO   = "0";
   localparam logic [7:0] CH_A_LOW  = "a";
   localparam logic [7:0] CH_A_UP   = "A";
   localparam logic [7:0] CH_Z_UP   = "Z";
   localparam logic [7:0] CH_M_LOW  = "m";
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TOP    = 8'hFF;
   localparam logic [71:0] URN_TEXT = "urn:uuid:";

   // Letter case used for generated hex digits and for the urn prefix.
   typedef enum logic [1:0] {CASE_LOWER, CASE_UPPER, CASE_MIXED} letter_case_type;

   // Ways of damaging a well-formed string.
   typedef enum logic [2:0] {
      DAMAGE_REPLACE, DAMAGE_DROP, DAMAGE_INSERT, DAMAGE_TRUNCATE, DAMAGE_EXTEND
   } damage_kind_type;

   // One predicted parse result.
   typedef struct {
      logic        ok;
      logic [63:0] high;
      logic [63:0] low;
   } uuid_result_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_in = '0;
   logic        req_is_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic        rsp_valid_res;
   logic [63:0] rsp_uuid_high;
   logic [63:0] rsp_uuid_low;

   // Parse model state.
   logic [5:0]  parse_pos;
   logic [1:0]  parse_form;
   logic        parse_err;
   logic [63:0] value_high;
   logic [63:0] value_low;

   uuid_result_type pending_uuids[$];
   logic [7:0]      text_buf[$];

   bit          idle_enable = 1'b1;
   int unsigned stall_left  = 0;
   int unsigned chars_sent  = 0;
   int unsigned strings_sent = 0;
   int unsigned mismatches  = 0;
   int unsigned cycle_count = 0;

   uuid_text_parser dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_in   (req_char_in),
      .req_is_last   (req_is_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_valid_res (rsp_valid_res),
      .rsp_uuid_high (rsp_uuid_high),
      .rsp_uuid_low  (rsp_uuid_low)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Parse model
   // ------------------------------------------------------------------------

   // Clear the parse state, as after reset and after every last character.
   function automatic void clear_parse();
      parse_pos  = '0;
      parse_form = FORM_PLAIN;
      parse_err  = 1'b0;
      value_high = '0;
      value_low  = '0;
   endfunction

   // Total string length that a form requires.
   function automatic logic [6:0] required_length(input logic [1:0] form);
      logic [6:0] n;
      case (form)
         FORM_PLAIN: n = LEN_PLAIN;
         FORM_HYPH:  n = LEN_HYPH;
         FORM_BRACE: n = LEN_BRACE;
         default:    n = LEN_URN;
      endcase
      return n;
   endfunction

   // Shift one hex digit into the 128-bit value, or flag the character.
   function automatic void shift_in_hex(input logic [7:0] c);
      logic [3:0] v;
      logic       hit;
      hit = 1'b1;
      if (c >= "0" && c <= "9") v = 4'(c - "0");
      else if (c >= "a" && c <= "f") v = 4'(c - "a" + 8'd10);
      else if (c >= "A" && c <= "F") v = 4'(c - "A" + 8'd10);
      else begin
         hit = 1'b0;
         v = '0;
      end
      if (!hit) parse_err = 1'b1;
      else {value_high, value_low} = {value_high[59:0], value_low, v};
   endfunction

   // One character of the 36-character body: a dash between the groups,
   // hex digits everywhere else.
   function automatic void take_body_char(input logic [5:0] at, input logic [7:0] c);
      if (at == 6'd8 || at == 6'd13 || at == 6'd18 || at == 6'd23) begin
         if (c != CHAR_DASH) parse_err = 1'b1;
      end else begin
         shift_in_hex(c);
      end
   endfunction

   // Advance the model by one accepted character; queue a result on the last.
   function automatic void parse_uuid_char(input logic [7:0] c, input logic last);
      logic [5:0]      p;
      logic [7:0]      folded;
      uuid_result_type res;
      p = parse_pos;
      // The first character picks the form; a dash at the ninth turns plain
      // into hyphenated.
      if (p == 0) begin
         if ((c | CASE_BIT) == CHAR_LOW_U) parse_form = FORM_URN;
         else if (c == CHAR_LBRACE) parse_form = FORM_BRACE;
         else parse_form = FORM_PLAIN;
      end
      if (parse_form == FORM_PLAIN && p == 6'd8 && c == CHAR_DASH) parse_form = FORM_HYPH;

      case (parse_form)
         FORM_PLAIN: begin
            if (p < 6'd32) shift_in_hex(c);
            else parse_err = 1'b1;
         end
         FORM_HYPH: begin
            if (p < 6'd36) take_body_char(p, c);
            else parse_err = 1'b1;
         end
         FORM_BRACE: begin
            if (p == 0) begin
               if (c != CHAR_LBRACE) parse_err = 1'b1;
            end else if (p <= 6'd36) begin
               take_body_char(p - 6'd1, c);
            end else if (p == 6'd37) begin
               if (c != CHAR_RBRACE) parse_err = 1'b1;
            end else begin
               parse_err = 1'b1;
            end
         end
         default: begin
            if (p < 6'd9) begin
               folded = (c >= CH_A_UP && c <= CH_Z_UP) ? c + CASE_BIT : c;
               if (folded != URN_TEXT[8*(8-p) +: 8]) parse_err = 1'b1;
            end else if (p < 6'd45) begin
               take_body_char(p - 6'd9, c);
            end else begin
               parse_err = 1'b1;
            end
         end
      endcase

      if (last) begin
         res.ok   = !parse_err && ({1'b0, p} + 7'd1 == required_length(parse_form));
         res.high = res.ok ? value_high : '0;
         res.low  = res.ok ? value_low : '0;
         pending_uuids.push_back(res);
         clear_parse();
      end else begin
         parse_pos = (p < POS_MAX) ? p + 6'd1 : POS_MAX;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   // Result-side stall, in random bursts while idling is enabled.
   always @(posedge clock) begin
      if (stall_left != 0) stall_left = stall_left - 1;
      else if (idle_enable && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 4);
      rsp_stall <= (stall_left != 0);
   end

   // Send one character and update the model once it is accepted.
   task automatic send_char(input logic [7:0] ch, input logic last);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= ch;
      req_is_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_uuid_char(ch, last);
      chars_sent++;
   endtask

   // Send the whole text buffer as one string.
   task automatic send_text();
      int i;
      for (i = 0; i < text_buf.size(); i++) begin
         send_char(text_buf[i], i == text_buf.size() - 1);
      end
      strings_sent++;
   endtask

   // Hex digit for a nibble in the requested letter case.
   function automatic logic [7:0] hex_char(input logic [3:0] v, input letter_case_type lc);
      logic upper;
      upper = (lc == CASE_UPPER) || (lc == CASE_MIXED && $urandom_range(0, 1) == 1);
      if (v < 4'd10) return CH_ZERO + 8'(v);
      return (upper ? CH_A_UP : CH_A_LOW) + 8'(v - 4'd10);
   endfunction

   // Fill the text buffer with a well-formed UUID string of the given form.
   task automatic build_uuid(input logic [1:0] form, input logic [127:0] value,
                             input letter_case_type lc);
      int         i;
      logic [7:0] ch;
      text_buf.delete();
      if (form == FORM_BRACE) text_buf.push_back(CHAR_LBRACE);
      if (form == FORM_URN) begin
         for (i = 0; i < 9; i++) begin
            ch = URN_TEXT[8*(8-i) +: 8];
            if (ch >= CH_A_LOW &&
                (lc == CASE_UPPER || (lc == CASE_MIXED && $urandom_range(0, 1) == 1)))
               ch = ch & ~CASE_BIT;
            text_buf.push_back(ch);
         end
      end
      for (i = 0; i < 32; i++) begin
         if (form != FORM_PLAIN && (i == 8 || i == 12 || i == 16 || i == 20))
            text_buf.push_back(CHAR_DASH);
         text_buf.push_back(hex_char(value[127-4*i -: 4], lc));
      end
      if (form == FORM_BRACE) text_buf.push_back(CHAR_RBRACE);
   endtask

   // A random form, value and letter case.
   task automatic build_random_uuid();
      logic [1:0] form;
      case ($urandom_range(0, 3))
         0:       form = FORM_PLAIN;
         1:       form = FORM_HYPH;
         2:       form = FORM_BRACE;
         default: form = FORM_URN;
      endcase
      build_uuid(form, {$urandom, $urandom, $urandom, $urandom},
                 letter_case_type'($urandom_range(0, 2)));
   endtask

   // Damage the text buffer in one random way.
   task automatic damage_text();
      int unsigned at;
      int unsigned n;
      at = $urandom_range(0, text_buf.size() - 1);
      case (damage_kind_type'($urandom_range(0, 4)))
         DAMAGE_REPLACE: text_buf[at] = 8'($urandom_range(0, 255));
         DAMAGE_DROP: begin
            if (text_buf.size() > 1) text_buf.delete(at);
         end
         DAMAGE_INSERT: text_buf.insert(at, hex_char(4'($urandom), CASE_MIXED));
         DAMAGE_TRUNCATE: begin
            n = $urandom_range(1, text_buf.size());
            while (text_buf.size() > n) void'(text_buf.pop_back());
         end
         default: begin
            n = $urandom_range(text_buf.size() + 1, 80);
            while (text_buf.size() < n) text_buf.push_back(8'($urandom_range(0, 255)));
         end
      endcase
   endtask

   // Random bytes of random length.
   task automatic build_noise();
      int unsigned n;
      n = $urandom_range(1, 70);
      text_buf.delete();
      while (text_buf.size() < n) text_buf.push_back(8'($urandom_range(0, 255)));
   endtask

   // ------------------------------------------------------------------------
   // Result monitor
   // ------------------------------------------------------------------------

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin : check_results
      uuid_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_uuids.size() == 0) begin
            note_mismatch("result with nothing pending", '0, {63'd0, rsp_valid_res});
         end else begin
            want = pending_uuids.pop_front();
            if (rsp_valid_res !== want.ok)
               note_mismatch("valid_res", 64'(want.ok), 64'(rsp_valid_res));
            if (rsp_uuid_high !== want.high) note_mismatch("uuid_high", want.high, rsp_uuid_high);
            if (rsp_uuid_low !== want.low) note_mismatch("uuid_low", want.low, rsp_uuid_low);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Well-formed strings of every form, with value and case extremes.
   task automatic test_each_form();
      build_uuid(FORM_PLAIN, '0, CASE_LOWER);
      send_text();
      build_uuid(FORM_HYPH, '1, CASE_UPPER);
      send_text();
      build_uuid(FORM_BRACE, {$urandom, $urandom, $urandom, $urandom}, CASE_MIXED);
      send_text();
      build_uuid(FORM_URN, {$urandom, $urandom, $urandom, $urandom}, CASE_UPPER);
      send_text();
      build_uuid(FORM_URN, '1, CASE_LOWER);
      send_text();
   endtask

   // Strings that must be rejected.
   task automatic test_bad_strings();
      // A lone zero byte, and a lone top byte, each ending its string.
      text_buf.delete();
      text_buf.push_back(CH_NUL);
      send_text();
      text_buf.delete();
      text_buf.push_back(CH_TOP);
      send_text();
      // Overlong: the position saturates well past every form.
      build_uuid(FORM_PLAIN, '1, CASE_LOWER);
      while (text_buf.size() < 70) text_buf.push_back(CH_A_LOW);
      send_text();
      // One character short of the plain form.
      build_uuid(FORM_PLAIN, '1, CASE_UPPER);
      void'(text_buf.pop_back());
      send_text();
      // Braced form without its closing brace.
      build_uuid(FORM_BRACE, '0, CASE_LOWER);
      void'(text_buf.pop_back());
      send_text();
      // Wrong letter in the urn prefix.
      build_uuid(FORM_URN, '0, CASE_MIXED);
      text_buf[2] = CH_M_LOW;
      send_text();
      // First dash one place late.
      build_uuid(FORM_HYPH, '0, CASE_LOWER);
      text_buf[8] = CH_ZERO;
      text_buf[9] = CHAR_DASH;
      send_text();
   endtask

   // Mostly well-formed strings, with damaged strings and noise mixed in.
   task automatic test_random_strings();
      int unsigned pick;
      while (chars_sent < 480 || strings_sent < 16) begin
         pick = $urandom_range(0, 9);
         if (pick < 9) build_random_uuid();
         if (pick >= 6 && pick < 9) damage_text();
         if (pick == 9) build_noise();
         send_text();
      end
   endtask

   // Back-to-back strings with no idling on either side.
   task automatic test_steady_stream();
      int i;
      idle_enable = 1'b0;
      for (i = 0; i < 8; i++) begin
         build_random_uuid();
         if ($urandom_range(0, 3) == 0) damage_text();
         send_text();
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      clear_parse();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_each_form();
      test_bad_strings();
      test_random_strings();
      test_steady_stream();

      // Drain outstanding results, then allow for the pipeline latency.
      req_valid <= 1'b0;
      while (pending_uuids.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/uuidp_pkg.sv
src/uuidp_char_class.sv
src/uuid_text_parser.sv
src/uuidp_checker.sv
tb/tb.sv
